FILE: hw/rtl/mvsm_pkg.sv
// ----------------------------------------------------------------------------
// mvsm_pkg
// Shared types and constants of the multi-voice sample mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package mvsm_pkg;

  localparam int OPCODE_W = 2;
  localparam int ADDR_W   = 14;
  localparam int SAMPLE_W = 16;
  localparam int LEN_W    = 15;
  localparam int GAIN_W   = 10;

  // Opcodes
  localparam logic [OPCODE_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_BG    = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_FX    = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_TICK  = 2'd3;

  localparam logic [LEN_W-1:0]  MAX_SPAN   = 15'd16384;
  localparam logic [LEN_W-1:0]  MIN_SPAN   = 15'd1;
  localparam logic [GAIN_W-1:0] UNITY_GAIN = 10'd256;

  localparam int MIX_MAX = 32767;
  localparam int MIX_MIN = -32768;

  // sample * gain: 16 bit signed times 11 bit signed (zero-extended gain)
  localparam int PROD_W = 27;
  // product / 256, truncated toward zero
  localparam int TERM_W = 19;

  // Address reduction: 14-bit address folded below the RAM depth by
  // compare-subtract of depth << k, k from RED_STEPS-1 down to 0.
  // Seven steps cover the smallest depth (256); RED_W holds the largest
  // depth shifted by six.
  localparam int RED_STEPS = 7;
  localparam int STEP_W    = 3;
  localparam int RED_W     = 27;

  typedef struct packed {
    logic clr;  // clear accumulator and pipeline
    logic en;   // a term is issued this cycle
  } mac_ctl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/mvsm_sample_ram.sv
// ----------------------------------------------------------------------------
// mvsm_sample_ram
// Sample store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mvsm_sample_ram
  import mvsm_pkg::*;
#(
  parameter int DEPTH = 16384,
  parameter int AW    = 14
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic signed [SAMPLE_W-1:0] wdata,
  input  logic [AW-1:0]              raddr,
  output logic signed [SAMPLE_W-1:0] rdata
);

  logic signed [SAMPLE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/mvsm_mac.sv
// ----------------------------------------------------------------------------
// mvsm_mac
// Shared multiply, truncate and accumulate unit for the voice terms.
// ----------------------------------------------------------------------------
`default_nettype none

module mvsm_mac
  import mvsm_pkg::*;
#(
  parameter int ACC_W = 23
) (
  input  logic                       clk,
  input  logic                       rst,
  input  mac_ctl_t                   ctl,
  input  logic [GAIN_W-1:0]          gain,
  input  logic signed [SAMPLE_W-1:0] rdata,   // arrives the cycle after issue
  output logic signed [ACC_W-1:0]    acc
);

  logic                     en1;
  logic                     en2;
  logic [GAIN_W-1:0]        gain1;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_adj;
  logic signed [PROD_W-1:0] shifted;
  logic signed [TERM_W-1:0] term;

  // round toward zero: bias negative products before the shift
  assign prod_adj = prod[PROD_W-1] ? prod + PROD_W'(255) : prod;
  assign shifted  = prod_adj >>> 8;
  assign term     = shifted[TERM_W-1:0];

  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      en1 <= 1'b0;
      en2 <= 1'b0;
    end else begin
      en1 <= ctl.en;
      en2 <= en1;
    end
  end

  always_ff @(posedge clk) begin
    gain1 <= gain;
    prod  <= rdata * $signed({1'b0, gain1});
    if (ctl.clr) begin
      acc <= '0;
    end else if (en2) begin
      acc <= acc + ACC_W'(term);
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/multi_voice_sample_mixer.sv
// ----------------------------------------------------------------------------
// multi_voice_sample_mixer
// Sample-playback mixer: sample RAM, one looping background voice and
// VOICES gain-scaled effect voices mixed into a saturated 16-bit sample.
//
// Input channel (in_valid/in_ready) carries one command per transfer:
// write a sample, start the background, start an effect, or tick. Every
// command gives exactly one result on the output channel (out_valid/
// out_ready): the mix on a tick (zero otherwise) and the slot taken by a
// started effect (VOICES when none or not applicable).
// One command is in work at a time. A tick walks the voices through the
// shared multiply-accumulate unit, one voice a cycle, then drains the
// multiply pipeline before the result register. Write and background
// start fold the address below the RAM depth by repeated compare-subtract;
// an effect start adds a slot search over the voices.
// in_ready returns together with out_valid, when the result is registered.
// The output register holds a result while out_ready is low; the next
// command is taken meanwhile and waits at its end for the register.
// Reset clears all voices and the background; RAM contents are kept.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_voice_sample_mixer
  import mvsm_pkg::*;
#(
  parameter int VOICES           = 8,
  parameter int SAMPLE_RAM_DEPTH = 16384,
  localparam int SLOT_W          = $clog2(VOICES + 1)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [OPCODE_W-1:0]        opcode,
  input  logic [ADDR_W-1:0]          address,
  input  logic signed [SAMPLE_W-1:0] sample_value,
  input  logic [LEN_W-1:0]           sound_length,
  input  logic [GAIN_W-1:0]          gain,
  input  logic                       repeat_req,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] mix_value,
  output logic [SLOT_W-1:0]          slot_taken
);

  localparam int AW    = (SAMPLE_RAM_DEPTH > 1) ? $clog2(SAMPLE_RAM_DEPTH) : 1;
  localparam int VW    = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int IW    = SLOT_W;
  localparam int ACC_W = TERM_W + $clog2(VOICES + 1);

  localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(MIX_MAX);
  localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(MIX_MIN);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_REDUCE = 7'b0000010,
    S_APPLY  = 7'b0000100,
    S_FIND   = 7'b0001000,
    S_TICK   = 7'b0010000,
    S_DRAIN  = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t state;

  // latched command
  logic [OPCODE_W-1:0]        op;
  logic signed [SAMPLE_W-1:0] sample;
  logic [LEN_W-1:0]           len;
  logic [GAIN_W-1:0]          vol;
  logic                       rep;
  logic [ADDR_W-1:0]          red;
  logic [STEP_W-1:0]          step;
  logic [IW-1:0]              idx;
  logic                       drain;
  logic [SLOT_W-1:0]          slot;

  // voice state
  logic              busy    [VOICES];
  logic              looping [VOICES];
  logic [AW-1:0]     vbase   [VOICES];
  logic [AW-1:0]     vptr    [VOICES];
  logic [LEN_W-1:0]  vspan   [VOICES];
  logic [ADDR_W-1:0] voff    [VOICES];
  logic [GAIN_W-1:0] vgain   [VOICES];

  logic              bg_on;
  logic [AW-1:0]     bg_base;
  logic [AW-1:0]     bg_ptr;
  logic [LEN_W-1:0]  bg_span;
  logic [ADDR_W-1:0] bg_offset;

  logic accept;
  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // address reduction step
  logic [RED_W-1:0] dk;
  logic             red_sub;
  logic [ADDR_W-1:0] red_next;
  assign dk       = RED_W'(SAMPLE_RAM_DEPTH) << step;
  assign red_sub  = {{(RED_W-ADDR_W){1'b0}}, red} >= dk;
  assign red_next = red_sub ? red - dk[ADDR_W-1:0] : red;

  logic [AW-1:0] red_ptr;
  assign red_ptr = AW'(red);

  // voice selected by the sequencer; the index past the last voice is the
  // background
  logic              is_bg;
  logic [VW-1:0]     vi;
  logic              cur_on;
  logic [AW-1:0]     cur_ptr;
  logic [AW-1:0]     cur_base;
  logic [LEN_W-1:0]  cur_span;
  logic [ADDR_W-1:0] cur_off;
  logic [GAIN_W-1:0] cur_gain;
  logic [AW:0]       ptr_inc;
  logic [AW-1:0]     ptr_next;
  logic [LEN_W-1:0]  off_inc;
  logic              end_hit;

  assign is_bg    = (idx == IW'(VOICES));
  assign vi       = idx[VW-1:0];
  assign cur_on   = is_bg ? bg_on     : busy[vi];
  assign cur_ptr  = is_bg ? bg_ptr    : vptr[vi];
  assign cur_base = is_bg ? bg_base   : vbase[vi];
  assign cur_span = is_bg ? bg_span   : vspan[vi];
  assign cur_off  = is_bg ? bg_offset : voff[vi];
  assign cur_gain = is_bg ? UNITY_GAIN : vgain[vi];

  assign ptr_inc  = {1'b0, cur_ptr} + (AW+1)'(1);
  assign ptr_next = (ptr_inc == (AW+1)'(SAMPLE_RAM_DEPTH)) ? '0 : ptr_inc[AW-1:0];
  assign off_inc  = {1'b0, cur_off} + LEN_W'(1);
  assign end_hit  = off_inc >= cur_span;

  // shared datapath
  logic                       ram_we;
  logic signed [SAMPLE_W-1:0] ram_rdata;
  mac_ctl_t                   mac_ctl;
  logic signed [ACC_W-1:0]    acc;

  assign ram_we      = (state == S_APPLY) && (op == OP_WRITE);
  assign mac_ctl.clr = accept;
  assign mac_ctl.en  = (state == S_TICK) && cur_on;

  mvsm_sample_ram #(
    .DEPTH (SAMPLE_RAM_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (red_ptr),
    .wdata (sample),
    .raddr (cur_ptr),
    .rdata (ram_rdata)
  );

  mvsm_mac #(
    .ACC_W (ACC_W)
  ) u_mac (
    .clk   (clk),
    .rst   (rst),
    .ctl   (mac_ctl),
    .gain  (cur_gain),
    .rdata (ram_rdata),
    .acc   (acc)
  );

  logic signed [SAMPLE_W-1:0] mix_sat;
  always_comb begin
    if (acc > ACC_MAX) begin
      mix_sat = SAMPLE_W'(MIX_MAX);
    end else if (acc < ACC_MIN) begin
      mix_sat = SAMPLE_W'(MIX_MIN);
    end else begin
      mix_sat = acc[SAMPLE_W-1:0];
    end
  end

  logic out_free;
  assign out_free = !out_valid || out_ready;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= (opcode == OP_TICK) ? S_TICK : S_REDUCE;
          end
        end
        S_REDUCE: begin
          if (step == '0) begin
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          state <= (op == OP_FX) ? S_FIND : S_DONE;
        end
        S_FIND: begin
          if (!busy[vi] || idx == IW'(VOICES - 1)) begin
            state <= S_DONE;
          end
        end
        S_TICK: begin
          if (is_bg) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (drain) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // command registers and counters
  always_ff @(posedge clk) begin
    if (accept) begin
      op     <= opcode;
      red    <= address;
      sample <= sample_value;
      len    <= (sound_length > MAX_SPAN) ? MAX_SPAN : sound_length;
      vol    <= gain;
      rep    <= repeat_req;
      step   <= STEP_W'(RED_STEPS - 1);
      idx    <= '0;
      drain  <= 1'b0;
      slot   <= SLOT_W'(VOICES);
    end else begin
      if (state == S_REDUCE) begin
        red  <= red_next;
        step <= step - STEP_W'(1);
      end
      if (state == S_FIND) begin
        if (!busy[vi]) begin
          slot <= SLOT_W'(idx);
        end else begin
          idx <= idx + IW'(1);
        end
      end
      if (state == S_TICK) begin
        idx <= idx + IW'(1);
      end
      if (state == S_DRAIN) begin
        drain <= 1'b1;
      end
    end
  end

  // effect voices
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < VOICES; i++) begin
        busy[i] <= 1'b0;
      end
    end else if (state == S_FIND && !busy[vi]) begin
      busy[vi]    <= 1'b1;
      looping[vi] <= rep;
      vbase[vi]   <= red_ptr;
      vptr[vi]    <= red_ptr;
      vspan[vi]   <= (len == '0) ? MIN_SPAN : len;
      voff[vi]    <= '0;
      vgain[vi]   <= vol;
    end else if (state == S_TICK && !is_bg && cur_on) begin
      if (end_hit) begin
        if (looping[vi]) begin
          voff[vi] <= '0;
          vptr[vi] <= cur_base;
        end else begin
          busy[vi] <= 1'b0;
        end
      end else begin
        voff[vi] <= off_inc[ADDR_W-1:0];
        vptr[vi] <= ptr_next;
      end
    end
  end

  // background voice
  always_ff @(posedge clk) begin
    if (rst) begin
      bg_on <= 1'b0;
    end else if (state == S_APPLY && op == OP_BG) begin
      bg_on     <= (len != '0);
      bg_base   <= red_ptr;
      bg_ptr    <= red_ptr;
      bg_span   <= len;
      bg_offset <= '0;
    end else if (state == S_TICK && is_bg && bg_on) begin
      if (end_hit) begin
        bg_offset <= '0;
        bg_ptr    <= bg_base;
      end else begin
        bg_offset <= off_inc[ADDR_W-1:0];
        bg_ptr    <= ptr_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      mix_value  <= (op == OP_TICK) ? mix_sat : '0;
      slot_taken <= slot;
    end
  end

  // checks
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> slot_taken <= SLOT_W'(VOICES))
    else $error("slot_taken beyond voice count");

  a_slot_no_mix: assert property (@(posedge clk) disable iff (rst)
    out_valid && slot_taken != SLOT_W'(VOICES) |-> mix_value == '0)
    else $error("effect start result carries a mix value");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("new transfer taken while a command is in work");

endmodule

`default_nettype wire

FILE: bench/tb_multi_voice_sample_mixer.sv
// ----------------------------------------------------------------------------
// tb_multi_voice_sample_mixer
// Self-checking bench for the sample mixer. Commands go in over the input
// channel and every result is compared against a cycle-free prediction of
// the RAM, background and effect voices. Before a tick, any RAM word it will
// read that was never loaded is written first.
// ----------------------------------------------------------------------------
module tb_multi_voice_sample_mixer;
  import mvsm_pkg::*;

  localparam int VOICES       = 8;
  localparam int RAM_DEPTH    = 16384;
  localparam int SLOT_W       = $clog2(VOICES + 1);
  localparam int LONG_SPAN    = 64;
  localparam int RANDOM_ITEMS = 1500;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_LIMIT  = 100000;

  localparam int FX_ADDR [9] = '{16383, 200, 5000, 16382, 0, 1, 16380, 2, 3};
  localparam int FX_LEN  [9] = '{0, 32767, 16384, 3, 1, 2, 5, 1, 4};
  localparam int FX_GAIN [9] = '{1023, 0, 256, 1023, 511, 512, 1, 768, 100};

  typedef struct packed {
    logic [OPCODE_W-1:0]        op;
    logic [ADDR_W-1:0]          addr;
    logic signed [SAMPLE_W-1:0] value;
    logic [LEN_W-1:0]           len;
    logic [GAIN_W-1:0]          gain;
    logic                       rep;
  } mix_cmd_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mix;
    logic [SLOT_W-1:0]          slot;
  } mix_result_t;

  class voice_mix_tracker;
    bit signed [SAMPLE_W-1:0] ram [RAM_DEPTH];
    bit written [RAM_DEPTH];
    bit busy [VOICES];
    bit looping [VOICES];
    int base [VOICES];
    int span [VOICES];
    int offs [VOICES];
    int vgain [VOICES];
    bit bg_on;
    int bg_base;
    int bg_span;
    int bg_offs;
    mix_result_t due [$];
    int failures;

    function void flag(string msg);
      failures++;
      if (failures <= 10) $display("[%0t] mismatch: %s", $time, msg);
    endfunction

    function int sample_at(int a);
      return int'(ram[a % RAM_DEPTH]);
    endfunction

    // first RAM word the next tick reads that was never loaded, -1 if none
    function int next_unwritten();
      int a;
      int i;
      if (bg_on) begin
        a = (bg_base + bg_offs) % RAM_DEPTH;
        if (!written[a]) return a;
      end
      for (i = 0; i < VOICES; i++) begin
        if (busy[i]) begin
          a = (base[i] + offs[i]) % RAM_DEPTH;
          if (!written[a]) return a;
        end
      end
      return -1;
    endfunction

    // busy voices that loop (by_loop) or have a long region
    function int held_voices(bit by_loop);
      int i;
      int n;
      n = 0;
      for (i = 0; i < VOICES; i++)
        if (busy[i] && (by_loop ? looping[i] : span[i] > LONG_SPAN)) n++;
      return n;
    endfunction

    function void take_command(mix_cmd_t c);
      mix_result_t r;
      int span_req;
      int acc;
      int prod;
      int i;
      bit placed;
      r.mix = '0;
      r.slot = SLOT_W'(VOICES);
      span_req = (c.len > MAX_SPAN) ? int'(MAX_SPAN) : int'(c.len);
      case (c.op)
        OP_WRITE: begin
          ram[c.addr] = c.value;
          written[c.addr] = 1'b1;
        end
        OP_BG: begin
          bg_on = (span_req != 0);
          bg_base = int'(c.addr);
          bg_span = span_req;
          bg_offs = 0;
        end
        OP_FX: begin
          placed = 1'b0;
          for (i = 0; i < VOICES; i++) begin
            if (!placed && !busy[i]) begin
              busy[i] = 1'b1;
              looping[i] = c.rep;
              base[i] = int'(c.addr);
              span[i] = (span_req == 0) ? 1 : span_req;
              offs[i] = 0;
              vgain[i] = int'(c.gain);
              r.slot = SLOT_W'(i);
              placed = 1'b1;
            end
          end
        end
        OP_TICK: begin
          acc = 0;
          if (bg_on) begin
            acc += sample_at(bg_base + bg_offs);
            bg_offs++;
            if (bg_offs >= bg_span) bg_offs = 0;
          end
          for (i = 0; i < VOICES; i++) begin
            if (busy[i]) begin
              prod = sample_at(base[i] + offs[i]) * vgain[i];
              // integer division truncates toward zero, as the Q2.8 scaling wants
              acc += prod / 256;
              offs[i]++;
              if (offs[i] >= span[i]) begin
                if (looping[i]) offs[i] = 0;
                else busy[i] = 1'b0;
              end
            end
          end
          if (acc > MIX_MAX) acc = MIX_MAX;
          if (acc < MIX_MIN) acc = MIX_MIN;
          r.mix = SAMPLE_W'(acc);
        end
      endcase
      due.push_back(r);
    endfunction

    function void check_result(logic signed [SAMPLE_W-1:0] mix, logic [SLOT_W-1:0] slot);
      mix_result_t e;
      if (due.size() == 0) begin
        flag($sformatf("result with no command pending, mix=%0d slot=%0d", mix, slot));
        return;
      end
      e = due.pop_front();
      if (mix !== e.mix)
        flag($sformatf("mix_value expected %0d got %0d", e.mix, mix));
      if (slot !== e.slot)
        flag($sformatf("slot_taken expected %0d got %0d", e.slot, slot));
    endfunction
  endclass

  logic                       clk;
  logic                       rst;
  logic                       in_valid;
  logic                       in_ready;
  logic [OPCODE_W-1:0]        opcode;
  logic [ADDR_W-1:0]          address;
  logic signed [SAMPLE_W-1:0] sample_value;
  logic [LEN_W-1:0]           sound_length;
  logic [GAIN_W-1:0]          gain;
  logic                       repeat_req;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [SAMPLE_W-1:0] mix_value;
  logic [SLOT_W-1:0]          slot_taken;

  voice_mix_tracker tracker;
  int results_seen;
  int items_sent;
  bit no_idle;

  multi_voice_sample_mixer #(
    .VOICES(VOICES),
    .SAMPLE_RAM_DEPTH(RAM_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .opcode(opcode),
    .address(address),
    .sample_value(sample_value),
    .sound_length(sound_length),
    .gain(gain),
    .repeat_req(repeat_req),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .mix_value(mix_value),
    .slot_taken(slot_taken)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int idle_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic mix_cmd_t make_cmd(logic [OPCODE_W-1:0] op, int addr, int value,
                                        int len, int g, bit rep);
    mix_cmd_t c;
    c.op = op;
    c.addr = ADDR_W'(addr);
    c.value = SAMPLE_W'(value);
    c.len = LEN_W'(len);
    c.gain = GAIN_W'(g);
    c.rep = rep;
    return c;
  endfunction

  function automatic mix_cmd_t random_cmd();
    mix_cmd_t c;
    c.op = OPCODE_W'($urandom);
    c.addr = ADDR_W'($urandom);
    c.value = SAMPLE_W'($urandom);
    c.len = LEN_W'($urandom);
    c.gain = GAIN_W'($urandom);
    c.rep = 1'($urandom);
    return c;
  endfunction

  function automatic int pick_length(bit allow_long);
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 0;
    if (!allow_long || r < 80) return $urandom_range(1, 16);
    if (r < 92) return $urandom_range(17, LONG_SPAN);
    if (r < 95) return 16384;
    if (r < 97) return 32767;
    return $urandom_range(LONG_SPAN + 1, 32767);
  endfunction

  task automatic drive_cmd(mix_cmd_t c);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    opcode <= c.op;
    address <= c.addr;
    sample_value <= c.value;
    sound_length <= c.len;
    gain <= c.gain;
    repeat_req <= c.rep;
    do @(posedge clk); while (!in_ready);
    tracker.take_command(c);
    items_sent++;
    gap = idle_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // a tick may only read loaded RAM, so load whatever it is about to reach
  task automatic send_cmd(mix_cmd_t c);
    mix_cmd_t fill;
    int a;
    if (c.op == OP_TICK) begin
      a = tracker.next_unwritten();
      while (a >= 0) begin
        fill = random_cmd();
        fill.op = OP_WRITE;
        fill.addr = ADDR_W'(a);
        drive_cmd(fill);
        a = tracker.next_unwritten();
      end
    end
    drive_cmd(c);
  endtask

  task automatic wait_all_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.due.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      tracker.check_result(mix_value, slot_taken);
      results_seen++;
    end
  end

  // result side: random back-pressure plus one long hold-off
  initial begin
    int idle_left;
    bit held_off;
    idle_left = 0;
    held_off = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held_off && results_seen >= 200) begin
        held_off = 1'b1;
        idle_left = HOLD_CYCLES;
      end
      if (idle_left > 0) begin
        out_ready <= 1'b0;
        idle_left--;
      end else begin
        out_ready <= 1'b1;
        idle_left = idle_gap();
      end
    end
  end

  initial begin
    #50000000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    mix_cmd_t c;
    int n;
    int i;
    int pick;
    int waited;
    bit paused;
    tracker = new();
    results_seen = 0;
    items_sent = 0;
    paused = 1'b0;
    no_idle = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    opcode = OP_WRITE;
    address = '0;
    sample_value = '0;
    sound_length = '0;
    gain = '0;
    repeat_req = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // nothing playing yet: silence
    send_cmd(make_cmd(OP_TICK, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(OP_WRITE, 16383, 32767, 0, 0, 0));
    send_cmd(make_cmd(OP_WRITE, 0, -32768, 0, 0, 0));
    send_cmd(make_cmd(OP_WRITE, 1, 1, 0, 0, 0));
    // background region wraps past the top of RAM
    send_cmd(make_cmd(OP_BG, 16383, 0, 2, 0, 0));
    repeat (3) send_cmd(make_cmd(OP_TICK, 0, 0, 0, 0, 0));
    // zero and overlong lengths, gain extremes, one loop, last start dropped
    for (i = 0; i < 9; i++)
      send_cmd(make_cmd(OP_FX, FX_ADDR[i], 0, FX_LEN[i], FX_GAIN[i], i == 3));
    repeat (2) send_cmd(make_cmd(OP_TICK, 0, 0, 0, 0, 0));
    // zero length stops the background
    send_cmd(make_cmd(OP_BG, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(OP_TICK, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(OP_BG, 100, 0, 32767, 0, 0));
    send_cmd(make_cmd(OP_TICK, 0, 0, 0, 0, 0));
    wait_all_results();

    // RAM fills count toward the item budget
    for (n = 0; items_sent < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if (!paused && items_sent >= RANDOM_ITEMS / 2) begin
        paused = 1'b1;
        wait_all_results();
      end
      c = random_cmd();
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        c.op = OP_TICK;
      end else if (pick < 65) begin
        c.op = OP_WRITE;
      end else if (pick < 90) begin
        c.op = OP_FX;
        // keep a few slots cycling: cap voices that never free
        c.len = LEN_W'(pick_length(tracker.held_voices(1'b0) < 3));
        c.rep = (tracker.held_voices(1'b1) < 2) && ($urandom_range(0, 9) < 2);
        case ($urandom_range(0, 9))
          0: c.gain = '0;
          1: c.gain = '1;
          2: c.gain = UNITY_GAIN;
          default: ;
        endcase
      end else begin
        c.op = OP_BG;
        c.len = LEN_W'(pick_length(1'b1));
      end
      send_cmd(c);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    waited = 0;
    while (tracker.due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);
    if (tracker.due.size() != 0)
      tracker.flag($sformatf("%0d results never arrived", tracker.due.size()));

    if (tracker.failures == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
